>>> sv/serd_pkg.sv
package serd_pkg;

  // default sizes
  localparam int DEF_RING_DEPTH          = 4096;
  localparam int DEF_LEFT_FIRST_LENGTH   = 167;
  localparam int DEF_LEFT_SECOND_LENGTH  = 257;
  localparam int DEF_RIGHT_FIRST_LENGTH  = 197;
  localparam int DEF_RIGHT_SECOND_LENGTH = 283;

  // register indexes
  localparam logic [2:0] REG_TAP_ONE   = 3'd0;
  localparam logic [2:0] REG_TAP_TWO   = 3'd1;
  localparam logic [2:0] REG_TAP_THREE = 3'd2;
  localparam logic [2:0] REG_LEVEL     = 3'd3;
  localparam logic [2:0] REG_DAMPING   = 3'd4;

  localparam logic [15:0] LEVEL_RESET = 16'd9830;
  localparam logic [15:0] LEVEL_MIN   = 16'd65;

  // tap weights and allpass gains, Q0.16
  localparam logic signed [16:0] W_NEAR   = 17'sd29491;
  localparam logic signed [16:0] W_CROSS  = 17'sd19661;
  localparam logic signed [16:0] W_FAR    = 17'sd13107;
  localparam logic signed [16:0] G_FIRST  = 17'sd36045;
  localparam logic signed [16:0] G_SECOND = 17'sd29491;

  // sequencer states
  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WRITE = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_H1    = 5'd4;
  localparam logic [4:0] S_H2    = 5'd5;
  localparam logic [4:0] S_H3    = 5'd6;
  localparam logic [4:0] S_MW    = 5'd7;
  localparam logic [4:0] S_WS    = 5'd8;
  localparam logic [4:0] S_D1    = 5'd9;
  localparam logic [4:0] S_D2    = 5'd10;
  localparam logic [4:0] S_ARD   = 5'd11;
  localparam logic [4:0] S_AB    = 5'd12;
  localparam logic [4:0] S_AW    = 5'd13;
  localparam logic [4:0] S_AG    = 5'd14;
  localparam logic [4:0] S_AO    = 5'd15;
  localparam logic [4:0] S_W1    = 5'd16;
  localparam logic [4:0] S_W2    = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  // sequencer to lane control
  typedef struct packed {
    logic [4:0] st;
    logic [1:0] tap;
    logic [1:0] pt;
    logic       cap;
    logic       stg;
    logic       clr;
  } ctl_t;

  function automatic logic signed [23:0] sat24_f(input logic signed [63:0] x);
    if (x > 64'sd8388607) return 24'sd8388607;
    if (x < -64'sd8388608) return -24'sd8388608;
    return x[23:0];
  endfunction

  function automatic logic signed [31:0] sat32_f(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sd2147483647;
    if (x < -64'sd2147483648) return -32'sd2147483648;
    return x[31:0];
  endfunction

  // round half up by 16 bits
  function automatic logic signed [63:0] rnd16_f(input logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

endpackage

>>> sv/serd_ram.sv
module serd_ram #(
  parameter int W = 24,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/serd_lane.sv
module serd_lane import serd_pkg::*; #(
  parameter int LEN_A = DEF_LEFT_FIRST_LENGTH,
  parameter int LEN_B = DEF_LEFT_SECOND_LENGTH,
  parameter int CW    = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [CW-1:0]       clr_addr_i,
  input  logic signed [23:0]  own_i,
  input  logic signed [23:0]  oth_i,
  input  logic [7:0]          f_i,
  input  logic [15:0]         coef_i,
  input  logic [15:0]         lvl_i,
  input  logic signed [23:0]  dry_i,
  output logic signed [23:0]  out_o
);

  localparam int AWA = $clog2(LEN_A);
  localparam int AWB = $clog2(LEN_B);

  logic signed [23:0] y_q [4];
  logic signed [47:0] h_q;
  logic signed [31:0] tap_q;
  logic signed [51:0] s_q;
  logic signed [55:0] p_q;
  logic signed [31:0] d_q;
  logic signed [23:0] x_q, b_q, w_q, o_q;
  logic [AWA-1:0]     pos_a_q;
  logic [AWB-1:0]     pos_b_q;

  logic signed [23:0] din, rd_a, rd_b, rd_s;
  logic signed [29:0] c1, c2, c3;
  logic signed [8:0]  fs;
  logic signed [55:0] acc;
  logic signed [16:0] wsel, gsel, coef_s, lvl_s;
  logic signed [33:0] diff;
  logic               we_a, we_b;

  assign din    = (ctl_i.tap == 2'd1) ? oth_i : own_i;
  assign fs     = signed'({1'b0, f_i});
  assign coef_s = signed'({1'b0, coef_i});
  assign lvl_s  = signed'({1'b0, lvl_i});
  assign rd_s   = ctl_i.stg ? rd_b : rd_a;
  assign gsel   = ctl_i.stg ? G_SECOND : G_FIRST;

  // doubled hermite coefficients
  assign c1 = 30'(y_q[2]) - 30'(y_q[0]);
  assign c2 = (30'(y_q[0]) <<< 1) - 30'(y_q[1]) * 30'sd5 + (30'(y_q[2]) <<< 2) - 30'(y_q[3]);
  assign c3 = (30'(y_q[3]) - 30'(y_q[0])) + 30'sd3 * (30'(y_q[1]) - 30'(y_q[2]));
  assign acc = 56'(h_q) * 56'(fs) + (56'(y_q[1]) <<< 25);
  assign diff = (34'(x_q) <<< 8) - 34'(d_q);

  // tap weight
  always_comb begin
    case (ctl_i.tap)
      2'd0:    wsel = W_NEAR;
      2'd1:    wsel = W_CROSS;
      default: wsel = W_FAR;
    endcase
  end

  // sample capture and datapath steps
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      y_q[ctl_i.pt] <= din;
    end
    case (ctl_i.st)
      S_WRITE: s_q   <= '0;
      S_H1:    h_q   <= 48'(c3) * 48'(fs) + (48'(c2) <<< 8);
      S_H2:    h_q   <= h_q * 48'(fs) + (48'(c1) <<< 16);
      S_H3:    tap_q <= 32'((acc + 56'sd16777216) >>> 25);
      S_MW:    s_q   <= s_q + 52'(tap_q) * 52'(wsel);
      S_WS:    x_q   <= sat24_f(64'((s_q + 52'sd32768) >>> 16));
      S_D1:    p_q   <= 56'(coef_s) * 56'(diff);
      S_ARD: begin
        if (!ctl_i.stg) begin
          x_q <= sat24_f((64'(d_q) + 64'sd128) >>> 8);
        end
      end
      S_AB: begin
        b_q <= rd_s;
        p_q <= 56'(gsel) * 56'(rd_s);
      end
      S_AW:    w_q   <= sat24_f(64'(x_q) + rnd16_f(64'(p_q)));
      S_AG:    p_q   <= 56'(gsel) * 56'(w_q);
      S_AO:    x_q   <= sat24_f(64'(b_q) - rnd16_f(64'(p_q)));
      S_W1:    p_q   <= 56'(lvl_s) * 56'(x_q);
      S_W2:    o_q   <= sat24_f(64'(dry_i) + rnd16_f(64'(p_q)));
      default: ;
    endcase
  end

  // damper and allpass positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q     <= '0;
      pos_a_q <= '0;
      pos_b_q <= '0;
    end else begin
      if (ctl_i.st == S_D2) begin
        d_q <= sat32_f(64'(d_q) + rnd16_f(64'(p_q)));
      end
      if (ctl_i.st == S_AO && !ctl_i.stg) begin
        pos_a_q <= (pos_a_q == AWA'(LEN_A - 1)) ? '0 : pos_a_q + 1'b1;
      end
      if (ctl_i.st == S_AO && ctl_i.stg) begin
        pos_b_q <= (pos_b_q == AWB'(LEN_B - 1)) ? '0 : pos_b_q + 1'b1;
      end
    end
  end

  // allpass delay lines, zeroed by the clearing pass
  assign we_a = ctl_i.clr ? (32'(clr_addr_i) < LEN_A) : (ctl_i.st == S_AO && !ctl_i.stg);
  assign we_b = ctl_i.clr ? (32'(clr_addr_i) < LEN_B) : (ctl_i.st == S_AO && ctl_i.stg);

  serd_ram #(.W(24), .D(LEN_A)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (ctl_i.clr ? clr_addr_i[AWA-1:0] : pos_a_q),
    .wdata_i (ctl_i.clr ? 24'd0 : w_q),
    .raddr_i (pos_a_q),
    .rdata_o (rd_a)
  );

  serd_ram #(.W(24), .D(LEN_B)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (ctl_i.clr ? clr_addr_i[AWB-1:0] : pos_b_q),
    .wdata_i (ctl_i.clr ? 24'd0 : w_q),
    .raddr_i (pos_b_q),
    .rdata_o (rd_b)
  );

  assign out_o = o_q;

endmodule

>>> sv/stereo_early_reflection_diffuser_top.sv
// Stereo early-reflection diffuser.
// Input stream (s_axis_*): one stereo frame per request, left sample in
// tdata[23:0], right sample in tdata[47:24], both signed Q1.23.
// Output stream (m_axis_*): one processed frame per input frame, same packing.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
// edge (0 tap one, 1 tap two, 2 tap three, 3 level, 4 damping); write only
// while idle. Unknown indexes are ignored.
// Each frame runs through a sequencer: ring write, four ring reads per tap for
// three taps (both ears read in parallel, one read per cycle from each ring
// memory), hermite and weighting steps, damper, two allpass stages and the wet
// mix. A new frame is taken only after the result of the last one is loaded
// into the output register, at the earliest in the following cycle. At or
// below the level threshold the frame skips these steps and its dry samples
// go straight to the output register.
// After reset the block zeroes its ring and allpass memories, one entry per
// cycle over max(RING_DEPTH, 512) clear addresses, with s_axis_tready low.
// The output register holds its result while m_axis_tready is low; the next
// frame may be accepted and processed, then waits before its load.
module stereo_early_reflection_diffuser_top import serd_pkg::*; #(
  parameter int RING_DEPTH          = DEF_RING_DEPTH,
  parameter int LEFT_FIRST_LENGTH   = DEF_LEFT_FIRST_LENGTH,
  parameter int LEFT_SECOND_LENGTH  = DEF_LEFT_SECOND_LENGTH,
  parameter int RIGHT_FIRST_LENGTH  = DEF_RIGHT_FIRST_LENGTH,
  parameter int RIGHT_SECOND_LENGTH = DEF_RIGHT_SECOND_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // left_in, right_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // left_out, right_out
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);

  localparam int RW    = $clog2(RING_DEPTH);
  localparam int CLR_N = (RING_DEPTH > 512) ? RING_DEPTH : 512;
  localparam int CW    = $clog2(CLR_N);
  localparam int IDW   = (RW > 12) ? RW : 12;
  localparam int IW    = IDW + 2;
  localparam int MAXD  = (RING_DEPTH - 4) * 256;

  logic [19:0] tap1_q, tap2_q, tap3_q;
  logic [15:0] lvl_q, coef_q;

  logic [4:0]         st_q, st_d;
  logic [CW-1:0]      clr_q;
  logic [RW-1:0]      wp_q, fp_q;
  logic [2:0]         jq;
  logic [1:0]         tq;
  logic               stg_q, byp_q;
  logic signed [23:0] dry_l_q, dry_r_q;
  logic               m_valid_q;
  logic [47:0]        m_data_q;

  logic [19:0]        dsel;
  logic               clamp;
  logic [IDW-1:0]     idel;
  logic [7:0]         frac;
  logic signed [IW-1:0] a_raw, a_wrap;
  logic               ring_we;
  logic [RW-1:0]      ring_wa;
  logic signed [23:0] rd_l, rd_r, out_l, out_r;
  logic               load;
  ctl_t               ctl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap1_q <= '0;
      tap2_q <= '0;
      tap3_q <= '0;
      lvl_q  <= LEVEL_RESET;
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TAP_ONE:   tap1_q <= cfg_data_i;
        REG_TAP_TWO:   tap2_q <= cfg_data_i;
        REG_TAP_THREE: tap3_q <= cfg_data_i;
        REG_LEVEL:     lvl_q  <= cfg_data_i[15:0];
        REG_DAMPING:   coef_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // tap delay split and clamp
  always_comb begin
    case (tq)
      2'd0:    dsel = tap1_q;
      2'd1:    dsel = tap2_q;
      default: dsel = tap3_q;
    endcase
  end
  assign clamp = 32'(dsel) > MAXD;
  assign idel  = clamp ? IDW'(RING_DEPTH - 4) : IDW'(dsel[19:8]);
  assign frac  = clamp ? 8'd0 : dsel[7:0];

  // ring read address, wrapped once
  assign a_raw  = IW'(signed'({1'b0, fp_q})) - IW'(signed'({1'b0, idel}))
                - IW'(signed'({1'b0, jq[1:0]}));
  assign a_wrap = (a_raw < 0) ? a_raw + IW'(RING_DEPTH) : a_raw;

  // sequencer
  assign load = !m_valid_q || m_axis_tready;
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_CLR:   if (clr_q == CW'(CLR_N - 1)) st_d = S_IDLE;
      S_IDLE:  if (s_axis_tvalid) st_d = S_WRITE;
      S_WRITE: st_d = (lvl_q > LEVEL_MIN) ? S_RD : S_OUT;
      S_RD:    if (jq == 3'd4) st_d = S_H1;
      S_H1:    st_d = S_H2;
      S_H2:    st_d = S_H3;
      S_H3:    st_d = S_MW;
      S_MW:    st_d = (tq == 2'd2) ? S_WS : S_RD;
      S_WS:    st_d = S_D1;
      S_D1:    st_d = S_D2;
      S_D2:    st_d = S_ARD;
      S_ARD:   st_d = S_AB;
      S_AB:    st_d = S_AW;
      S_AW:    st_d = S_AG;
      S_AG:    st_d = S_AO;
      S_AO:    st_d = stg_q ? S_W1 : S_ARD;
      S_W1:    st_d = S_W2;
      S_W2:    st_d = S_OUT;
      S_OUT:   if (load) st_d = S_IDLE;
      default: st_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_CLR;
      clr_q     <= '0;
      wp_q      <= '0;
      fp_q      <= '0;
      jq        <= '0;
      tq        <= '0;
      stg_q     <= 1'b0;
      byp_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (st_q == S_WRITE) begin
        fp_q  <= wp_q;
        wp_q  <= (wp_q == RW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        byp_q <= !(lvl_q > LEVEL_MIN);
        tq    <= '0;
        jq    <= '0;
        stg_q <= 1'b0;
      end
      if (st_q == S_RD) jq <= (jq == 3'd4) ? 3'd0 : jq + 1'b1;
      if (st_q == S_MW) tq <= tq + 1'b1;
      if (st_q == S_AO) stg_q <= 1'b1;
      // output register
      if (st_q == S_OUT && load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      dry_l_q <= signed'(s_axis_tdata[23:0]);
      dry_r_q <= signed'(s_axis_tdata[47:24]);
    end
    if (st_q == S_OUT && load) begin
      m_data_q <= byp_q ? {dry_r_q, dry_l_q} : {out_r, out_l};
    end
  end

  // reflection rings, zeroed by the clearing pass
  assign ring_we = (st_q == S_CLR) ? (32'(clr_q) < RING_DEPTH) : (st_q == S_WRITE);
  assign ring_wa = (st_q == S_CLR) ? clr_q[RW-1:0] : wp_q;

  serd_ram #(.W(24), .D(RING_DEPTH)) u_ring_l (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_wa),
    .wdata_i ((st_q == S_CLR) ? 24'd0 : dry_l_q),
    .raddr_i (a_wrap[RW-1:0]),
    .rdata_o (rd_l)
  );

  serd_ram #(.W(24), .D(RING_DEPTH)) u_ring_r (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_wa),
    .wdata_i ((st_q == S_CLR) ? 24'd0 : dry_r_q),
    .raddr_i (a_wrap[RW-1:0]),
    .rdata_o (rd_r)
  );

  // lane control
  assign ctl.st  = st_q;
  assign ctl.tap = tq;
  assign ctl.pt  = 2'(jq - 3'd1);
  assign ctl.cap = (st_q == S_RD) && (jq != 3'd0);
  assign ctl.stg = stg_q;
  assign ctl.clr = (st_q == S_CLR);

  serd_lane #(.LEN_A(LEFT_FIRST_LENGTH), .LEN_B(LEFT_SECOND_LENGTH), .CW(CW)) u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .clr_addr_i (clr_q),
    .own_i      (rd_l),
    .oth_i      (rd_r),
    .f_i        (frac),
    .coef_i     (coef_q),
    .lvl_i      (lvl_q),
    .dry_i      (dry_l_q),
    .out_o      (out_l)
  );

  serd_lane #(.LEN_A(RIGHT_FIRST_LENGTH), .LEN_B(RIGHT_SECOND_LENGTH), .CW(CW)) u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .clr_addr_i (clr_q),
    .own_i      (rd_r),
    .oth_i      (rd_l),
    .f_i        (frac),
    .coef_i     (coef_q),
    .lvl_i      (lvl_q),
    .dry_i      (dry_r_q),
    .out_o      (out_r)
  );

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLR) |-> !m_axis_tvalid)
    else $error("result shown during memory clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (st_q == S_WRITE))
    else $error("accepted frame not written to rings");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < RING_DEPTH)
    else $error("ring write pointer out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && !load) |=> (st_q == S_OUT))
    else $error("result dropped while output stalled");

endmodule
